// ===== rtl/core/utf8cd_pkg.sv =====
// ---------------------------------------------------------------------------
// utf8cd_pkg
// Shared types and byte constants for the UTF-8 code point decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8cd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned PAY_W  = 6;

	localparam logic [BYTE_W-1:0] BOM_B0     = 8'hEF;
	localparam logic [BYTE_W-1:0] BOM_B1     = 8'hBB;
	localparam logic [BYTE_W-1:0] BOM_B2     = 8'hBF;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
	localparam logic [BYTE_W-1:0] PAY2_MASK  = 8'h1F;
	localparam logic [BYTE_W-1:0] PAY3_MASK  = 8'h0F;
	localparam logic [BYTE_W-1:0] PAY4_MASK  = 8'h07;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic            emit;
		logic [CP_W-1:0] cp;
	} dec_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_codepoint_decoder.sv =====
// ---------------------------------------------------------------------------
// utf8_codepoint_decoder
// Turns a UTF-8 byte stream into code points, dropping each byte order mark
// that does not directly follow a dropped one.
//
// Input channel: in_valid / in_stall / in_byte, one byte per beat.
// Output channel: out_valid / out_stall / code_point, one code point per
// completed character; bytes that only open or extend a sequence, and the
// three bytes of a dropped mark, give no output beat.
// Path: a byte that completes a character is held in the input register,
// then its code point in the result register.
// Throughput: one byte per cycle while the receiver takes beats; decode is a
// single shift-or and state update between the two registers.
// Stall: a held result blocks the byte in the input register, which in turn
// raises in_stall; a stalled output beat keeps its value.
// Reset: arst_n clears both valid flags and the sequence state, so the block
// starts waiting for a lead byte with mark checking armed.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder
	import utf8cd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CP_W-1:0]        code_point
);

	logic              free;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              fire;
	dec_res_t          res;

	assign fire = valid_s1 && free;

	utf8cd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_stall (in_stall),
		.advance  (free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	utf8cd_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	utf8cd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire && res.emit),
		.cp         (res.cp),
		.free       (free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point)
	);

endmodule

`default_nettype wire

// ===== rtl/core/utf8cd_in_stage.sv =====
// ---------------------------------------------------------------------------
// utf8cd_in_stage
// Input register: captures one byte beat and holds it until decode takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8cd_in_stage
	import utf8cd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   in_stall,
	input  wire logic              advance,
	output logic                   valid_s1,
	output logic [BYTE_W-1:0]      byte_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/utf8cd_decode.sv =====
// ---------------------------------------------------------------------------
// utf8cd_decode
// Sequence state and per-byte decode, including byte order mark removal.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8cd_decode
	import utf8cd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [BYTE_W-1:0] byte_s1,
	output dec_res_t               res
);

	logic [1:0]      pend_q, pend_d;
	logic [CP_W-1:0] part_q, part_d;
	logic            cand_q, cand_d;
	logic            second_q, second_d;
	logic            after_q, after_d;
	logic [CP_W-1:0] shifted;
	logic            may_mark;

	assign shifted  = {part_q[CP_W-PAY_W-1:0], byte_s1[PAY_W-1:0]};
	assign may_mark = (byte_s1 == BOM_B0) && !after_q;

	always_comb begin
		pend_d   = pend_q;
		part_d   = part_q;
		cand_d   = cand_q;
		second_d = second_q;
		after_d  = after_q;
		res.emit = 1'b0;
		res.cp   = shifted;
		if (pend_q != PEND_NONE) begin
			part_d = shifted;
			pend_d = pend_q - 2'd1;
			if (cand_q && pend_d == PEND_ONE) begin
				second_d = (byte_s1 == BOM_B1);
			end
			if (pend_d == PEND_NONE) begin
				cand_d   = 1'b0;
				second_d = 1'b0;
				if (cand_q && second_q && byte_s1 == BOM_B2) begin
					// mark dropped
					after_d = 1'b1;
					part_d  = '0;
				end else begin
					res.emit = 1'b1;
				end
			end
		end else begin
			after_d  = 1'b0;
			cand_d   = 1'b0;
			second_d = 1'b0;
			if ((byte_s1 & LEAD2_MASK) == LEAD2_TAG) begin
				part_d = CP_W'(byte_s1 & PAY2_MASK);
				pend_d = PEND_ONE;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_TAG) begin
				part_d = CP_W'(byte_s1 & PAY3_MASK);
				pend_d = PEND_TWO;
				cand_d = may_mark;
			end else if ((byte_s1 & LEAD4_MASK) == LEAD4_TAG) begin
				part_d = CP_W'(byte_s1 & PAY4_MASK);
				pend_d = PEND_THREE;
			end else begin
				res.emit = 1'b1;
				res.cp   = CP_W'(byte_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= PEND_NONE;
			part_q   <= '0;
			cand_q   <= 1'b0;
			second_q <= 1'b0;
			after_q  <= 1'b0;
		end else if (fire) begin
			pend_q   <= pend_d;
			part_q   <= part_d;
			cand_q   <= cand_d;
			second_q <= second_d;
			after_q  <= after_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/utf8cd_out_reg.sv =====
// ---------------------------------------------------------------------------
// utf8cd_out_reg
// Result register: holds a code point beat until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8cd_out_reg
	import utf8cd_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic [CP_W-1:0] cp,
	output logic                 free,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [CP_W-1:0]      code_point
);

	logic valid_q;
	logic [CP_W-1:0] cp_q;

	assign free       = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign code_point = cp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q <= cp;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/utf8cd_chk.sv =====
// ---------------------------------------------------------------------------
// utf8cd_chk
// Port-level checks for the UTF-8 code point decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8cd_chk
	import utf8cd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [BYTE_W-1:0] in_byte,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [CP_W-1:0]   code_point
);

	// held output beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point))
		else $error("output beat changed while stalled");

	// stalled input beat stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte))
		else $error("input beat changed while stalled");

	// input backpressure only comes from a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// no output beat and no input stall right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid && !in_stall)
		else $error("beat present right after reset");

endmodule

bind utf8_codepoint_decoder utf8cd_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.in_byte    (in_byte),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.code_point (code_point)
);

`default_nettype wire

// ===== tb/tb_utf8_codepoint_decoder.sv =====
// ---------------------------------------------------------------------------
// tb_utf8_codepoint_decoder
// Self-checking bench for the UTF-8 code point decoder. A byte-level decode
// model inside a scoreboard class predicts each code point from the accepted
// input beats. Every output beat is compared in order against that
// prediction. Stimulus is a directed byte list followed by random characters,
// byte order marks and noise, run in phases with different sender idle and
// receiver stall rates.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_utf8_codepoint_decoder;
	import utf8cd_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_BYTES  = 400;
	localparam int DRAIN_CYCLES = 10;

	class cp_scoreboard;
		logic [1:0]      pend;
		logic [CP_W-1:0] acc;
		bit              mark_cand;
		bit              mark_bb;
		bit              after_bom;
		logic [CP_W-1:0] cp_q[$];
		int              errors;

		function new();
			pend = PEND_NONE;
			acc = '0;
			mark_cand = 1'b0;
			mark_bb = 1'b0;
			after_bom = 1'b0;
			errors = 0;
		endfunction

		task report(string what, logic [CP_W-1:0] got, logic [CP_W-1:0] want);
			$display("mismatch: %s got %h want %h", what, got, want);
			errors++;
		endtask

		function void note_byte(logic [BYTE_W-1:0] b);
			bit may_bom;
			if (pend != PEND_NONE) begin
				acc = (acc << PAY_W) | CP_W'(b & CONT_MASK);
				pend = pend - 2'd1;
				if (mark_cand) begin
					if (pend == PEND_ONE) begin
						mark_bb = (b == BOM_B1);
					end else if (pend == PEND_NONE && mark_bb && b == BOM_B2) begin
						// byte order mark dropped
						mark_cand = 1'b0;
						mark_bb = 1'b0;
						after_bom = 1'b1;
						acc = '0;
						return;
					end
				end
				if (pend == PEND_NONE) begin
					mark_cand = 1'b0;
					mark_bb = 1'b0;
					cp_q.push_back(acc);
				end
				return;
			end
			may_bom = (b == BOM_B0) && !after_bom;
			after_bom = 1'b0;
			mark_cand = 1'b0;
			mark_bb = 1'b0;
			if ((b & LEAD2_MASK) == LEAD2_TAG) begin
				acc = CP_W'(b & PAY2_MASK);
				pend = PEND_ONE;
			end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
				acc = CP_W'(b & PAY3_MASK);
				pend = PEND_TWO;
				mark_cand = may_bom;
			end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
				acc = CP_W'(b & PAY4_MASK);
				pend = PEND_THREE;
			end else begin
				cp_q.push_back(CP_W'(b));
			end
		endfunction

		task check_cp(logic [CP_W-1:0] cp);
			logic [CP_W-1:0] want;
			if (cp_q.size() == 0) begin
				report("unexpected code_point", cp, '0);
			end else begin
				want = cp_q.pop_front();
				if (cp !== want)
					report("code_point", cp, want);
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [CP_W-1:0]   code_point;

	cp_scoreboard sb = new();
	int in_pct = 0;
	int out_pct = 0;
	int n_sent = 0;
	int idle_cnt = 0;

	localparam logic [BYTE_W-1:0] DIRECTED_SEQ [24] = '{
		8'h00, 8'h7F, 8'hFF, 8'h80,
		8'hC2, 8'hA9,
		8'hF4, 8'h8F, 8'hBF, 8'hBF,
		BOM_B0, BOM_B1, BOM_B2,
		BOM_B0, BOM_B1, BOM_B2,
		BOM_B0, BOM_B1, 8'h00,
		BOM_B0, 8'h41, BOM_B2,
		8'hC3, 8'h41
	};

	utf8_codepoint_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_pct);
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(in_byte);
			if (out_valid && !out_stall)
				sb.check_cp(code_point);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("tb_utf8_codepoint_decoder: errors");
				$finish;
			end
		end
	end

	task send_byte(logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < in_pct) begin
			in_valid <= 1'b0;
			in_byte <= BYTE_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	function logic [BYTE_W-1:0] rand_cont();
		return {2'b10, 6'($urandom_range(63))};
	endfunction

	task send_unit();
		int kind;
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_byte(BYTE_W'($urandom_range(127)));
		end else if (kind < 45) begin
			send_byte({3'b110, 5'($urandom)});
			send_byte(rand_cont());
		end else if (kind < 60) begin
			send_byte({4'b1110, 4'($urandom)});
			send_byte(rand_cont());
			send_byte(rand_cont());
		end else if (kind < 70) begin
			send_byte({5'b11110, 3'($urandom)});
			send_byte(rand_cont());
			send_byte(rand_cont());
			send_byte(rand_cont());
		end else if (kind < 76) begin
			send_byte(BOM_B0);
			send_byte(BOM_B1);
			send_byte(BOM_B2);
		end else if (kind < 80) begin
			// broken mark
			send_byte(BOM_B0);
			if ($urandom_range(1)) begin
				send_byte(BOM_B1);
				send_byte(BYTE_W'($urandom));
			end else begin
				send_byte(BYTE_W'($urandom));
				send_byte($urandom_range(1) ? BOM_B2 : BYTE_W'($urandom));
			end
		end else if (kind < 88) begin
			send_byte(BYTE_W'($urandom));
		end else if (kind < 92) begin
			send_byte($urandom_range(1) ? BYTE_W'($urandom_range(248, 255)) : rand_cont());
		end else if (kind < 96) begin
			// unchecked continuation
			send_byte({3'b110, 5'($urandom)});
			send_byte(BYTE_W'($urandom));
		end else begin
			// truncated sequence runs into the next character
			send_byte({5'b11110, 3'($urandom)});
			send_byte(rand_cont());
		end
	endtask

	task drain_pause();
		@(posedge clk);
		while (sb.cp_q.size() != 0)
			@(posedge clk);
	endtask

	task run_phase(int ip, int op, int nbytes);
		int start;
		start = n_sent;
		in_pct = ip;
		out_pct = op;
		while (n_sent - start < nbytes)
			send_unit();
		in_valid <= 1'b0;
		drain_pause();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_SEQ[i])
			send_byte(DIRECTED_SEQ[i]);
		in_valid <= 1'b0;
		drain_pause();
		run_phase(0, 0, PHASE_BYTES);
		run_phase(47, 0, PHASE_BYTES);
		run_phase(0, 47, PHASE_BYTES);
		run_phase(8, 8, PHASE_BYTES);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.cp_q.size() == 0)
			$display("tb_utf8_codepoint_decoder: clean");
		else
			$display("tb_utf8_codepoint_decoder: errors");
		$finish;
	end

endmodule

`default_nettype wire
